/* sv/rcpps_pkg.sv */
// ----------------------------------------------------------------------------
// rcpps_pkg
// Shared codes, widths and register map for the RC pulse pair switch decoder.
// ----------------------------------------------------------------------------
package rcpps_pkg;

  // Item field widths
  localparam int unsigned FuncWidth   = 2;
  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned PosWidth    = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned AttWidth    = 4;

  // Stream bus widths (whole bytes)
  localparam int unsigned InDataWidth   = 8;
  localparam int unsigned InUserWidth   = 8;
  localparam int unsigned OutDataWidth  = 24;
  localparam int unsigned OutUserWidth  = 8;

  // Configuration port
  localparam int unsigned ApbAddrWidth = 5;
  localparam int unsigned ApbDataWidth = 32;

  typedef logic [ValueWidth-1:0]  value_t;
  typedef logic [AttWidth-1:0]    att_t;

  // Command carried with each tick
  typedef enum logic [FuncWidth-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_FULL  = 2'd1,
    FUNC_QUICK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Switch position of a result
  typedef enum logic [PosWidth-1:0] {
    POS_OFF = 2'd0,
    POS_MID = 2'd1,
    POS_ON  = 2'd2
  } pos_e;

  // Reading status of a result
  typedef enum logic [StatusWidth-1:0] {
    STAT_OK      = 2'd0,
    STAT_TIMEOUT = 2'd1,
    STAT_NOISY   = 2'd2
  } status_e;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_TIMEOUT  = 3'd0,
    REG_NOISE    = 3'd1,
    REG_ATTEMPTS = 3'd2,
    REG_MID_LOW  = 3'd3,
    REG_MID_HIGH = 3'd4
  } reg_e;

  // Register reset values
  localparam value_t TimeoutReset  = 16'd28000;
  localparam value_t NoiseReset    = 16'd75;
  localparam att_t   AttemptsReset = 4'd6;
  localparam value_t MidLowReset   = 16'd1300;
  localparam value_t MidHighReset  = 16'd1700;

endpackage

/* sv/rc_pulse_pair_switch_decoder.sv */
// Each accepted item is first held in the input register and processed as it leaves it;
// a result it causes is loaded into the output register and shown on the master side.
// Throughput: one tick item per cycle; the slave side only stalls when a
// result is due while the output register still holds an untaken result.
// Reset (rst_ni low, asynchronous): reading idle, pipeline empty, registers
// back to their defaults (timeout 28000, noise 75, attempts 6, mid 1300/1700).
// ----------------------------------------------------------------------------
// rc_pulse_pair_switch_decoder
// Per-microsecond RC pulse width decoder with pair averaging, noise retry
// and off/mid/on switch classification.
// ----------------------------------------------------------------------------
module rc_pulse_pair_switch_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave side: tdata[0] pin_level; tuser[1:0] func
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rcpps_pkg::InDataWidth-1:0]  s_axis_tdata,
  input  logic [rcpps_pkg::InUserWidth-1:0]  s_axis_tuser,
  // Master side: tdata[15:0] pulse_value, tdata[17:16] switch_position;
  // tuser[1:0] status
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rcpps_pkg::OutDataWidth-1:0] m_axis_tdata,
  output logic [rcpps_pkg::OutUserWidth-1:0] m_axis_tuser,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcpps_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [rcpps_pkg::ApbDataWidth-1:0] pwdata,
  output logic [rcpps_pkg::ApbDataWidth-1:0] prdata,
  output logic                               pready
);

  import rcpps_pkg::*;

  localparam int unsigned CmpWidth = (COUNT_WIDTH > ValueWidth) ? COUNT_WIDTH : ValueWidth;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CmpWidth-1:0]    cmp_t;

  localparam count_t CountMax = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_END,
    PH_WAIT_RISE,
    PH_HIGH
  } phase_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  value_t timeout_q, noise_q, mid_low_q, mid_high_q;
  att_t   attempts_q;
  logic   cfg_wr;
  reg_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_e'(paddr[ApbAddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TimeoutReset;
      noise_q    <= NoiseReset;
      attempts_q <= AttemptsReset;
      mid_low_q  <= MidLowReset;
      mid_high_q <= MidHighReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TIMEOUT:  timeout_q  <= pwdata[ValueWidth-1:0];
        REG_NOISE:    noise_q    <= pwdata[ValueWidth-1:0];
        REG_ATTEMPTS: attempts_q <= pwdata[AttWidth-1:0];
        REG_MID_LOW:  mid_low_q  <= pwdata[ValueWidth-1:0];
        REG_MID_HIGH: mid_high_q <= pwdata[ValueWidth-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_TIMEOUT:  prdata = {{(ApbDataWidth-ValueWidth){1'b0}}, timeout_q};
      REG_NOISE:    prdata = {{(ApbDataWidth-ValueWidth){1'b0}}, noise_q};
      REG_ATTEMPTS: prdata = {{(ApbDataWidth-AttWidth){1'b0}}, attempts_q};
      REG_MID_LOW:  prdata = {{(ApbDataWidth-ValueWidth){1'b0}}, mid_low_q};
      REG_MID_HIGH: prdata = {{(ApbDataWidth-ValueWidth){1'b0}}, mid_high_q};
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic  in_valid_q;
  func_e func_q;
  logic  pin_q;
  logic  advance;
  logic  emit_c;

  assign advance       = in_valid_q & (~emit_c | ~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      func_q <= func_e'(s_axis_tuser[FuncWidth-1:0]);
      pin_q  <= s_axis_tdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // Reading state
  // --------------------------------------------------------------------------
  phase_e phase_q, phase_d;
  logic   quick_q, quick_d;
  count_t elapsed_q, elapsed_d;
  count_t width_q, width_d;
  value_t first_q, first_d;
  logic   second_q, second_d;
  att_t   att_q, att_d;

  // Working values of this tick
  logic    start;
  phase_e  ph;
  logic    quick, second;
  count_t  elapsed, width, elapsed_inc;
  value_t  first;
  att_t    att, att_inc;
  logic    done, timed_out;
  count_t  w_cnt;
  value_t  w;
  value_t  diff;
  logic [ValueWidth:0] pair_sum;
  value_t  res_value;
  status_e res_status;

  always_comb begin
    start = (phase_q == PH_IDLE) && ((func_q == FUNC_FULL) || (func_q == FUNC_QUICK));

    // A start command reloads the reading state on this very tick
    quick   = start ? (func_q == FUNC_QUICK) : quick_q;
    second  = start ? 1'b0 : second_q;
    att     = start ? '0   : att_q;
    first   = start ? '0   : first_q;
    ph      = start ? PH_WAIT_END : phase_q;
    elapsed = start ? '0   : elapsed_q;
    width   = start ? '0   : width_q;

    phase_d   = ph;
    quick_d   = quick;
    second_d  = second;
    att_d     = att;
    first_d   = first;
    elapsed_d = elapsed;
    width_d   = width;

    done       = 1'b0;
    w_cnt      = '0;
    emit_c     = 1'b0;
    res_value  = '0;
    res_status = STAT_OK;

    // Edge tracking of one pulse measurement
    unique case (ph)
      PH_WAIT_END: begin
        if (!pin_q) phase_d = PH_WAIT_RISE;
      end
      PH_WAIT_RISE: begin
        if (pin_q) begin
          phase_d = PH_HIGH;
          width_d = count_t'(1);
        end
      end
      PH_HIGH: begin
        if (pin_q) begin
          if (width != CountMax) width_d = width + count_t'(1);
        end else begin
          done  = 1'b1;
          w_cnt = width;
        end
      end
      default: ;
    endcase

    // Timeout, unless the falling edge came first
    elapsed_inc = (elapsed != CountMax) ? elapsed + count_t'(1) : elapsed;
    timed_out   = (cmp_t'(elapsed_inc) >= cmp_t'(timeout_q)) || (elapsed_inc == CountMax);
    if (ph != PH_IDLE && !done) begin
      elapsed_d = elapsed_inc;
      if (timed_out) begin
        done  = 1'b1;
        w_cnt = '0;
      end
    end

    w        = value_t'(cmp_t'(w_cnt));
    diff     = (first > w) ? first - w : w - first;
    pair_sum = {1'b0, first} + {1'b0, w};
    att_inc  = att + att_t'(1);

    // Outcome of a finished measurement
    if (done) begin
      if (quick) begin
        emit_c     = 1'b1;
        res_value  = w;
        res_status = (w == '0) ? STAT_TIMEOUT : STAT_OK;
      end else if (!second) begin
        if (w == '0) begin
          emit_c     = 1'b1;
          res_status = STAT_TIMEOUT;
        end else begin
          first_d   = w;
          second_d  = 1'b1;
          phase_d   = PH_WAIT_END;
          elapsed_d = '0;
          width_d   = '0;
        end
      end else if (diff > noise_q) begin
        att_d = att_inc;
        if (att_inc >= attempts_q) begin
          emit_c     = 1'b1;
          res_status = STAT_NOISY;
        end else begin
          second_d  = 1'b0;
          phase_d   = PH_WAIT_END;
          elapsed_d = '0;
          width_d   = '0;
        end
      end else begin
        emit_c    = 1'b1;
        res_value = pair_sum[ValueWidth:1];
      end
    end

    if (emit_c) phase_d = PH_IDLE;
    if (!in_valid_q) emit_c = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      quick_q   <= 1'b0;
      elapsed_q <= '0;
      width_q   <= '0;
      first_q   <= '0;
      second_q  <= 1'b0;
      att_q     <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      quick_q   <= quick_d;
      elapsed_q <= elapsed_d;
      width_q   <= width_d;
      first_q   <= first_d;
      second_q  <= second_d;
      att_q     <= att_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic    out_valid_q;
  value_t  out_value_q;
  pos_e    out_pos_q, res_pos;
  status_e out_status_q;
  logic    load;

  always_comb begin
    if (res_value < mid_low_q)       res_pos = POS_OFF;
    else if (res_value > mid_high_q) res_pos = POS_ON;
    else                             res_pos = POS_MID;
  end

  assign load = advance & emit_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_value_q  <= res_value;
      out_pos_q    <= res_pos;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-ValueWidth-PosWidth){1'b0}}, out_pos_q, out_value_q};
  assign m_axis_tuser  = {{(OutUserWidth-StatusWidth){1'b0}}, out_status_q};

endmodule

/* sv/rcpps_checker.sv */
// ----------------------------------------------------------------------------
// rcpps_checker
// Port-level checks on the RC pulse pair switch decoder.
// ----------------------------------------------------------------------------
module rcpps_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [rcpps_pkg::InDataWidth-1:0]  s_axis_tdata,
  input logic [rcpps_pkg::InUserWidth-1:0]  s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [rcpps_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic [rcpps_pkg::OutUserWidth-1:0] m_axis_tuser,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [rcpps_pkg::ApbAddrWidth-1:0] paddr,
  input logic [rcpps_pkg::ApbDataWidth-1:0] pwdata,
  input logic [rcpps_pkg::ApbDataWidth-1:0] prdata,
  input logic                               pready
);

  import rcpps_pkg::*;

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Failed readings report a zero width
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[StatusWidth-1:0] != STAT_OK) |->
      (m_axis_tdata[ValueWidth-1:0] == '0))
    else $error("failed reading with nonzero width");

  // A result that waits may not block the slave side when the master takes it
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("slave side stalled while master side ready");

  // The configuration port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("configuration access stalled");

endmodule

bind rc_pulse_pair_switch_decoder rcpps_checker u_rcpps_checker (.*);

/* bench/rc_pulse_pair_switch_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_pair_switch_decoder_tb
// Self-checking bench for the RC pulse pair switch decoder. Tick items are fed
// from a queue, the decoder's behaviour is predicted per accepted tick, and
// every reading that comes out is compared field by field with the oldest
// prediction. Register settings change between phases while the decoder idles.
// ----------------------------------------------------------------------------
module rc_pulse_pair_switch_decoder_tb;
  import rcpps_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;

  // Measurement progress inside one reading
  typedef enum logic [1:0] {
    MEAS_IDLE,
    MEAS_WAIT_END,
    MEAS_WAIT_RISE,
    MEAS_HIGH
  } meas_e;

  typedef struct packed {
    func_e func;
    logic  pin;
  } tick_t;

  typedef struct {
    value_t  value;
    pos_e    pos;
    status_e status;
  } reading_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InDataWidth-1:0]   s_axis_tdata  = '0;  // [0] pin_level
  logic [InUserWidth-1:0]   s_axis_tuser  = '0;  // [1:0] func
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_axis_tdata;        // [15:0] pulse_value, [17:16] switch_position
  logic [OutUserWidth-1:0]  m_axis_tuser;        // [1:0] status
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [ApbAddrWidth-1:0]  paddr   = '0;
  logic [ApbDataWidth-1:0]  pwdata  = '0;
  logic [ApbDataWidth-1:0]  prdata;
  logic                     pready;

  // Stimulus and expectation stores
  tick_t    ticks_to_send[$];
  reading_t pending_readings[$];

  // Predicted register copies
  value_t cfg_timeout  = TimeoutReset;
  value_t cfg_noise    = NoiseReset;
  att_t   cfg_attempts = AttemptsReset;
  value_t cfg_mid_low  = MidLowReset;
  value_t cfg_mid_high = MidHighReset;

  // Predicted decoder state
  meas_e  meas_phase    = MEAS_IDLE;
  logic   quick_mode    = 1'b0;
  value_t elapsed_count = '0;
  value_t width_count   = '0;
  value_t first_width   = '0;
  logic   second_pulse  = 1'b0;
  att_t   attempts_used = '0;

  // Handshake bookkeeping
  logic        tick_taken   = 1'b0;
  logic        result_taken = 1'b0;
  logic        send_gaps    = 1'b1;
  logic        recv_gaps    = 1'b1;
  logic        hold_req     = 1'b0;
  int unsigned hold_len     = 0;
  int unsigned hold_left    = 0;
  int unsigned send_wait    = 0;
  int unsigned recv_wait    = 0;

  // Tallies
  int unsigned items_queued    = 0;
  int unsigned items_taken     = 0;
  int unsigned reading_ticks   = 0;
  int unsigned readings_due    = 0;
  int unsigned input_stalls    = 0;
  int unsigned settings_count  = 0;
  int unsigned n_ok            = 0;
  int unsigned n_timeout       = 0;
  int unsigned n_noisy         = 0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;

  rc_pulse_pair_switch_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  function automatic void start_pulse();
    meas_phase    = MEAS_WAIT_END;
    elapsed_count = '0;
    width_count   = '0;
  endfunction

  function automatic void finish_reading(value_t v, status_e s);
    reading_t r;
    r.value  = v;
    r.pos    = (v < cfg_mid_low) ? POS_OFF : (v > cfg_mid_high) ? POS_ON : POS_MID;
    r.status = s;
    pending_readings.push_back(r);
    readings_due++;
    meas_phase = MEAS_IDLE;
  endfunction

  task automatic advance_decoder(input func_e func, input logic pin);
    logic                done;
    value_t              w;
    value_t              diff;
    logic [ValueWidth:0] sum;
    done = 1'b0;
    w    = '0;
    // a start command only counts while idle
    if (meas_phase == MEAS_IDLE) begin
      if (func != FUNC_FULL && func != FUNC_QUICK) return;
      quick_mode    = (func == FUNC_QUICK);
      second_pulse  = 1'b0;
      attempts_used = '0;
      first_width   = '0;
      start_pulse();
    end
    reading_ticks++;
    case (meas_phase)
      MEAS_WAIT_END: begin
        if (!pin) meas_phase = MEAS_WAIT_RISE;
      end
      MEAS_WAIT_RISE: begin
        if (pin) begin
          meas_phase  = MEAS_HIGH;
          width_count = value_t'(1);
        end
      end
      default: begin
        if (pin) begin
          if (width_count != '1) width_count++;
        end else begin
          done = 1'b1;
          w    = width_count;
        end
      end
    endcase
    // falling edge wins over the timeout
    if (!done) begin
      if (elapsed_count != '1) elapsed_count++;
      if (elapsed_count >= cfg_timeout || elapsed_count == '1) begin
        done = 1'b1;
        w    = '0;
      end
    end
    if (!done) return;
    if (quick_mode) begin
      finish_reading(w, (w == '0) ? STAT_TIMEOUT : STAT_OK);
      return;
    end
    if (!second_pulse) begin
      if (w == '0) begin
        finish_reading('0, STAT_TIMEOUT);
        return;
      end
      first_width  = w;
      second_pulse = 1'b1;
      start_pulse();
      return;
    end
    diff = (first_width > w) ? first_width - w : w - first_width;
    if (diff > cfg_noise) begin
      attempts_used = attempts_used + 1'b1;
      if (attempts_used >= cfg_attempts) begin
        finish_reading('0, STAT_NOISY);
        return;
      end
      second_pulse = 1'b0;
      start_pulse();
      return;
    end
    sum = {1'b0, first_width} + {1'b0, w};
    finish_reading(sum[ValueWidth:1], STAT_OK);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: acceptance, prediction and run limit
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("rc_pulse_pair_switch_decoder regression: fail");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      advance_decoder(func_e'(s_axis_tuser[FuncWidth-1:0]), s_axis_tdata[0]);
      tick_taken = 1'b1;
      items_taken++;
    end else if (rst_ni && s_axis_tvalid) begin
      input_stalls++;
    end
  end

  // Tick driver: one item per handshake, random gap after each when gaps are enabled
  always @(negedge clk_i) begin : feed_ticks
    tick_t nxt;
    if (rst_ni && (!s_axis_tvalid || tick_taken)) begin
      tick_taken = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (ticks_to_send.size() > 0) begin
        nxt = ticks_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataWidth-1){1'b0}}, nxt.pin};
        s_axis_tuser  <= {{(InUserWidth-FuncWidth){1'b0}}, nxt.func};
        send_wait = send_gaps ? $urandom_range(0, 6) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall per item when gaps are enabled, plus the occasional long hold
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req  = 1'b0;
    end
    if (result_taken) begin
      result_taken = 1'b0;
      recv_wait    = recv_gaps ? $urandom_range(0, 6) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_taken = 1'b1;
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: pulse_value %0d", m_axis_tdata[ValueWidth-1:0]);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata[ValueWidth-1:0] !== want.value) begin
          $error("pulse_value: expected %0d, got %0d", want.value,
                 m_axis_tdata[ValueWidth-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[ValueWidth+PosWidth-1:ValueWidth] !== want.pos) begin
          $error("switch_position: expected %0d, got %0d", want.pos,
                 m_axis_tdata[ValueWidth+PosWidth-1:ValueWidth]);
          fail_count++;
        end
        if (m_axis_tuser[StatusWidth-1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status,
                 m_axis_tuser[StatusWidth-1:0]);
          fail_count++;
        end
        case (want.status)
          STAT_OK:      n_ok++;
          STAT_TIMEOUT: n_timeout++;
          default:      n_noisy++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_tick(func_e func, logic pin);
    tick_t t;
    t.func = func;
    t.pin  = pin;
    ticks_to_send.push_back(t);
    items_queued++;
  endfunction

  function automatic void queue_level(logic pin, int unsigned n);
    repeat (n) queue_tick(FUNC_TICK, pin);
  endfunction

  // APB write then read-back of one register
  task automatic write_reg(reg_e idx, logic [ApbDataWidth-1:0] val);
    logic [ApbDataWidth-1:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== val) begin
      $error("register %0d read-back: expected %0d, got %0d", idx, val, got);
      fail_count++;
    end
    case (idx)
      REG_TIMEOUT:  cfg_timeout  = val[ValueWidth-1:0];
      REG_NOISE:    cfg_noise    = val[ValueWidth-1:0];
      REG_ATTEMPTS: cfg_attempts = val[AttWidth-1:0];
      REG_MID_LOW:  cfg_mid_low  = val[ValueWidth-1:0];
      default:      cfg_mid_high = val[ValueWidth-1:0];
    endcase
  endtask

  task automatic apply_settings(int unsigned tmo, int unsigned noise, int unsigned att,
                                int unsigned lo, int unsigned hi);
    write_reg(REG_TIMEOUT,  tmo);
    write_reg(REG_NOISE,    noise);
    write_reg(REG_ATTEMPTS, att);
    write_reg(REG_MID_LOW,  lo);
    write_reg(REG_MID_HIGH, hi);
    settings_count++;
  endtask

  // Hold off until every tick is taken, the reading has ended and all
  // readings are in; low ticks drive any unfinished reading to its end.
  task automatic settle();
    logic quiet;
    quiet = 1'b0;
    while (!quiet) begin
      @(negedge clk_i);
      if (items_taken == items_queued) begin
        if (meas_phase != MEAS_IDLE) queue_level(1'b0, 8);
        else if (pending_readings.size() == 0) quiet = 1'b1;
      end
    end
    repeat (4) @(negedge clk_i);
  endtask

  // One reading as a receiver would send it, with some jitter and noise
  task automatic queue_reading(logic quick, int unsigned wmax);
    logic lead_high;
    int   pulses;
    int   w;
    int   first_w;
    lead_high = ($urandom_range(0, 3) == 0);
    pulses    = quick ? 1 : 2 * $urandom_range(1, 3);
    first_w   = 1;
    queue_tick(quick ? FUNC_QUICK : FUNC_FULL, lead_high);
    if (lead_high) queue_level(1'b1, $urandom_range(0, 3));
    for (int i = 0; i < pulses; i++) begin
      if (i % 2 == 0) begin
        w       = $urandom_range(1, wmax);
        first_w = w;
      end else if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(1, wmax + 12);
      end else begin
        w = first_w + int'($urandom_range(0, 4)) - 2;
        if (w < 1) w = 1;
      end
      queue_level(1'b0, $urandom_range(1, 3));
      // stray command in the low gap, normally ignored while busy
      if ($urandom_range(0, 9) == 0) queue_tick(func_e'($urandom_range(1, 3)), 1'b0);
      queue_level(1'b1, w);
    end
    queue_tick(FUNC_TICK, 1'b0);
  endtask

  // Mostly proper readings, some noise bursts and idle stretches
  task automatic queue_mixed_traffic(int unsigned n);
    int unsigned mark;
    int unsigned pick;
    mark = items_queued;
    while (items_queued - mark < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_reading(1'b0, 20);
      end else if (pick < 70) begin
        queue_reading(1'b1, 20);
      end else if (pick < 85) begin
        repeat ($urandom_range(3, 12))
          queue_tick(func_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 5))
          queue_tick($urandom_range(0, 1) ? FUNC_NONE : FUNC_TICK, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    int unsigned phase_no;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: ignored idle ticks, quick reading with the pin already
    // high, full reading with a start command arriving while busy
    queue_tick(FUNC_TICK, 1'b1);
    queue_tick(FUNC_NONE, 1'b0);
    queue_tick(FUNC_NONE, 1'b1);
    queue_tick(FUNC_QUICK, 1'b1);
    queue_tick(FUNC_TICK, 1'b1);
    queue_tick(FUNC_TICK, 1'b0);
    queue_level(1'b1, 3);
    queue_tick(FUNC_TICK, 1'b0);
    queue_tick(FUNC_FULL, 1'b0);
    queue_level(1'b1, 2);
    queue_tick(FUNC_QUICK, 1'b0);
    queue_tick(FUNC_TICK, 1'b0);
    queue_level(1'b1, 2);
    queue_tick(FUNC_NONE, 1'b0);
    settle();

    // Zero timeout acts as one tick; zero attempts acts as one
    apply_settings(0, 0, 0, 0, 0);
    queue_tick(FUNC_QUICK, 1'b1);
    queue_tick(FUNC_FULL, 1'b0);
    settle();

    // Falling edge on the timeout tick, then a second pulse that times out
    apply_settings(4, 0, 0, 2, 2);
    queue_tick(FUNC_QUICK, 1'b0);
    queue_level(1'b1, 2);
    queue_tick(FUNC_TICK, 1'b0);
    queue_tick(FUNC_FULL, 1'b0);
    queue_tick(FUNC_TICK, 1'b1);
    queue_level(1'b0, 2);
    queue_level(1'b1, 3);
    settle();

    // Random and directed phases, each under its own register setting
    phase_no = 1;
    while ((phase_no <= 11 || readings_due < 40) && phase_no < 40) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      case (phase_no)
        2: begin
          apply_settings(1, 16'hFFFF, 15, 0, 0);
          queue_mixed_traffic(15);
        end
        4: begin
          // long receiver hold while short quick readings keep coming
          apply_settings(40, 3, 2, 2, 4);
          send_gaps = 1'b0;
          @(posedge clk_i);
          hold_len = 400;
          hold_req = 1'b1;
          repeat (25) begin
            queue_tick(FUNC_QUICK, 1'b0);
            queue_tick(FUNC_TICK, 1'b1);
            queue_tick(FUNC_TICK, 1'b0);
          end
        end
        6: begin
          // short pulses under the widest timeout, without gaps
          send_gaps = 1'b0;
          recv_gaps = 1'b0;
          apply_settings(16'hFFFF, 0, 1, 16'hFFFF, 16'hFFFF);
          queue_tick(FUNC_QUICK, 1'b0);
          queue_level(1'b1, 5);
          queue_tick(FUNC_TICK, 1'b0);
          queue_tick(FUNC_FULL, 1'b0);
          queue_level(1'b1, 5);
          queue_level(1'b0, 2);
          queue_level(1'b1, 5);
          queue_tick(FUNC_TICK, 1'b0);
        end
        8: begin
          apply_settings(50, 0, 15, 0, 16'hFFFF);
          queue_mixed_traffic(15);
        end
        10: begin
          apply_settings(90, 16'hFFFF, 1, 16'hFFFF, 0);
          queue_mixed_traffic(15);
        end
        default: begin
          apply_settings($urandom_range(3, 90), $urandom_range(0, 6), $urandom_range(0, 5),
                         $urandom_range(0, 24), $urandom_range(0, 30));
          queue_mixed_traffic(15);
        end
      endcase
      settle();
      phase_no++;
    end

    repeat (8) @(negedge clk_i);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      fail_count++;
    end
    $display("Run covered %0d ticks inside readings under %0d register settings, %0d input stalls.",
             reading_ticks, settings_count, input_stalls);
    $display("Readings checked: %0d ok, %0d timed out, %0d too noisy.",
             n_ok, n_timeout, n_noisy);
    if (fail_count == 0) begin
      $display("rc_pulse_pair_switch_decoder regression: pass");
    end else begin
      $display("rc_pulse_pair_switch_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* rc_pulse_pair_switch_decoder.f */
sv/rcpps_pkg.sv
sv/rc_pulse_pair_switch_decoder.sv
sv/rcpps_checker.sv
bench/rc_pulse_pair_switch_decoder_tb.sv
